[sv/ifmt_pkg.sv]
// Package for the integer to ASCII formatter: transfer payload types, command and
// status structs, kind codes and the fixed text tables.
// Depends on nothing; used by every module of the block.
package ifmt_pkg;

    localparam logic [2:0] KIND_DEC  = 3'd0;
    localparam logic [2:0] KIND_HEXL = 3'd1;
    localparam logic [2:0] KIND_HEXU = 3'd2;
    localparam logic [2:0] KIND_PTR  = 3'd3;
    localparam logic [2:0] KIND_CHAR = 3'd4;

    localparam logic [4:0] DEC_DIGITS = 5'd10;
    localparam logic [4:0] HEX_DIGITS = 5'd8;
    localparam logic [4:0] PTR_DIGITS = 5'd16;
    localparam logic [4:0] DABBLE_LAST_STEP = 5'd31;

    localparam logic [2:0] NIL_LEN  = 3'd5;
    localparam logic [2:0] NILL_LEN = 3'd6;
    localparam logic [2:0] CHAR_LEN = 3'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_t;

    typedef enum logic [1:0] {
        SEL_PREFIX = 2'd0,
        SEL_DIGIT  = 2'd1,
        SEL_TEXT   = 2'd2
    } sel_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic strip;
        logic emit;
        sel_t sel;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic kind_ok;
        logic is_dec;
        logic has_digits;
        logic has_prefix;
        logic prefix_last;
        logic text_last;
        logic dabble_last;
        logic strip_more;
        logic digit_last;
        logic out_free;
    } stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else if (upper) begin
            c = 8'h41 + {4'h0, nib} - 8'd10;
        end else begin
            c = 8'h61 + {4'h0, nib} - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [7:0] nil_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6e;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6c;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] nill_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h4e;
            3'd2:    c = 8'h49;
            3'd3:    c = 8'h4c;
            3'd4:    c = 8'h4c;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage

[sv/ifmt_datapath.sv]
// Datapath of the integer to ASCII formatter: operand registers, binary to BCD
// shift-and-add-3 converter, digit shifter and the output register.
// Depends on ifmt_pkg; driven by ifmt_ctrl through cmd_t and reports through stat_t.
module ifmt_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  ifmt_pkg::in_t   item,
    input  ifmt_pkg::cmd_t  cmd,
    input  logic            result_ready,
    output ifmt_pkg::stat_t stat,
    output ifmt_pkg::out_t  result,
    output logic            result_valid
);
    import ifmt_pkg::*;

    logic [2:0]  kind_reg;
    logic [63:0] value_reg;
    logic [31:0] bin_reg;
    logic [63:0] dig_reg;
    logic [4:0]  cnt_reg;
    logic [4:0]  step_reg;
    logic [2:0]  pos_reg;
    out_t        result_reg;
    logic        result_valid_reg;

    logic [39:0] bcd_adj;
    logic [31:0] load_word;
    logic        ptr_null;
    logic        char_null;
    logic [2:0]  text_len;
    logic [3:0]  top_nib;
    logic [7:0]  ch;

    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            if (dig_reg[24 + 4 * i +: 4] >= 4'd5) begin
                bcd_adj[4 * i +: 4] = dig_reg[24 + 4 * i +: 4] + 4'd3;
            end else begin
                bcd_adj[4 * i +: 4] = dig_reg[24 + 4 * i +: 4];
            end
        end
    end

    assign load_word = (item.kind == KIND_DEC && item.value[31]) ?
                       32'd0 - item.value[31:0] : item.value[31:0];
    assign ptr_null  = (value_reg == 64'd0);
    assign char_null = (value_reg[7:0] == 8'd0);
    assign top_nib   = dig_reg[63:60];

    always_comb
    begin
        if (kind_reg == KIND_PTR) begin
            text_len = NIL_LEN;
        end else if (char_null) begin
            text_len = NILL_LEN;
        end else begin
            text_len = CHAR_LEN;
        end
    end

    always_comb
    begin
        stat.kind_ok     = (kind_reg <= KIND_CHAR);
        stat.is_dec      = (kind_reg == KIND_DEC);
        stat.has_digits  = (kind_reg == KIND_DEC) || (kind_reg == KIND_HEXL) ||
                           (kind_reg == KIND_HEXU) || (kind_reg == KIND_PTR && !ptr_null);
        stat.has_prefix  = (kind_reg == KIND_DEC && value_reg[31]) ||
                           (kind_reg == KIND_PTR && !ptr_null);
        stat.prefix_last = (kind_reg == KIND_DEC) ? 1'b1 : (pos_reg == 3'd1);
        stat.text_last   = (pos_reg == text_len - 3'd1);
        stat.dabble_last = (step_reg == DABBLE_LAST_STEP);
        stat.strip_more  = (top_nib == 4'd0) && (cnt_reg != 5'd1);
        stat.digit_last  = (cnt_reg == 5'd1);
        stat.out_free    = !result_valid_reg || result_ready;
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_PREFIX:
            begin
                if (kind_reg == KIND_DEC) begin
                    ch = 8'h2d;
                end else if (pos_reg == 3'd0) begin
                    ch = 8'h30;
                end else begin
                    ch = 8'h78;
                end
            end
            SEL_DIGIT:
            begin
                ch = hex_char(top_nib, kind_reg == KIND_HEXU);
            end
            SEL_TEXT:
            begin
                if (kind_reg == KIND_PTR) begin
                    ch = nil_char(pos_reg);
                end else if (char_null) begin
                    ch = nill_char(pos_reg);
                end else begin
                    ch = value_reg[7:0];
                end
            end
            default:
            begin
                ch = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            kind_reg  <= item.kind;
            value_reg <= item.value;
            bin_reg   <= load_word;
            step_reg  <= 5'd0;
            pos_reg   <= 3'd0;
            case (item.kind)
                KIND_DEC:
                begin
                    dig_reg <= 64'd0;
                    cnt_reg <= DEC_DIGITS;
                end
                KIND_HEXL, KIND_HEXU:
                begin
                    dig_reg <= {item.value[31:0], 32'd0};
                    cnt_reg <= HEX_DIGITS;
                end
                default:
                begin
                    dig_reg <= item.value;
                    cnt_reg <= PTR_DIGITS;
                end
            endcase
        end else if (cmd.dabble) begin
            dig_reg[63:24] <= {bcd_adj[38:0], bin_reg[31]};
            bin_reg        <= {bin_reg[30:0], 1'b0};
            step_reg       <= step_reg + 5'd1;
        end else if (cmd.strip || (cmd.emit && cmd.sel == SEL_DIGIT)) begin
            dig_reg <= {dig_reg[59:0], 4'h0};
            cnt_reg <= cnt_reg - 5'd1;
        end else if (cmd.emit) begin
            pos_reg <= pos_reg + 3'd1;
        end
        if (cmd.emit) begin
            result_reg.out_char <= ch;
            result_reg.last     <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            result_valid_reg <= 1'b1;
        end else if (result_ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

[sv/ifmt_ctrl.sv]
// Controller of the integer to ASCII formatter: one-hot state machine that runs
// the BCD conversion, leading zero strip and character emission.
// Depends on ifmt_pkg; commands ifmt_datapath through cmd_t.
module ifmt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  ifmt_pkg::stat_t stat,
    output logic            item_ready,
    output ifmt_pkg::cmd_t  cmd
);
    import ifmt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_START  = 7'b0000010,
        ST_DABBLE = 7'b0000100,
        ST_STRIP  = 7'b0001000,
        ST_PREFIX = 7'b0010000,
        ST_DIGITS = 7'b0100000,
        ST_TEXT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!stat.kind_ok) begin
                    state_next = ST_IDLE;
                end else if (stat.is_dec) begin
                    state_next = ST_DABBLE;
                end else if (stat.has_digits) begin
                    state_next = ST_STRIP;
                end else begin
                    state_next = ST_TEXT;
                end
            end
            ST_DABBLE:
            begin
                cmd.dabble = 1'b1;
                if (stat.dabble_last) begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if (stat.strip_more) begin
                    cmd.strip = 1'b1;
                end else if (stat.has_prefix) begin
                    state_next = ST_PREFIX;
                end else begin
                    state_next = ST_DIGITS;
                end
            end
            ST_PREFIX:
            begin
                cmd.sel = SEL_PREFIX;
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.prefix_last) begin
                        state_next = ST_DIGITS;
                    end
                end
            end
            ST_DIGITS:
            begin
                cmd.sel  = SEL_DIGIT;
                cmd.last = stat.digit_last;
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.digit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TEXT:
            begin
                cmd.sel  = SEL_TEXT;
                cmd.last = stat.text_last;
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.text_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/integer_to_ascii_formatter.sv]
// Integer to ASCII formatter: takes one item at a time and sends its text one
// character per transfer, most significant first, with last on the final one.
// A decimal item first runs the 32 steps of the shift-and-add-3 BCD converter,
// then strips leading zeros and emits its characters, with a minus sign first
// when negative. Hex and non-null pointer items strip leading zeros and emit,
// with a 0x prefix first on pointers; text items only emit. An unused kind code
// is dropped with no output. The output register lets the last character wait
// while the next item is taken. Depends on ifmt_pkg, ifmt_ctrl and ifmt_datapath.
module integer_to_ascii_formatter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  ifmt_pkg::in_t  item,
    output logic           result_valid,
    input  logic           result_ready,
    output ifmt_pkg::out_t result
);
    import ifmt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ifmt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .stat       (stat),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    ifmt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result_ready (result_ready),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("Input taken again right after a transfer.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result_valid || result_ready))
        else $error("Character emitted over a pending result.");

    a_midtext_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> !item_ready)
        else $error("Block idle while an item's text is unfinished.");
`endif

endmodule

[tb/integer_to_ascii_formatter_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for integer_to_ascii_formatter: a directed table and then
// random items, every character compared with a text predictor held in the bench.
// Depends on ifmt_pkg and the integer_to_ascii_formatter RTL.
module integer_to_ascii_formatter_tb;
    import ifmt_pkg::*;

    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS = 76;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;

    typedef logic [7:0] text_t[$];

    typedef struct {
        logic [2:0]  kind;
        logic [63:0] value;
        string       text;
    } row_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    in_t  item;
    logic result_valid;
    logic result_ready;
    out_t result;

    out_t expected_chars[$];
    int   error_count;
    int   chars_seen;
    bit   bulk_started;
    bit   sender_done;

    integer_to_ascii_formatter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    function automatic text_t text_of(string s);
        text_t t;
        for (int i = 0; i < s.len(); i++) begin
            t.push_back(s[i]);
        end
        return t;
    endfunction

    function automatic text_t digits_of(logic [63:0] v, int unsigned base, bit upper);
        text_t       t;
        logic [7:0]  d;
        if (v == 64'd0) begin
            t.push_front("0");
        end
        while (v != 64'd0) begin
            d = 8'(v % base);
            if (d < 8'd10) begin
                t.push_front(8'("0") + d);
            end else if (upper) begin
                t.push_front(8'("A") + d - 8'd10);
            end else begin
                t.push_front(8'("a") + d - 8'd10);
            end
            v = v / base;
        end
        return t;
    endfunction

    function automatic text_t format_text(in_t it);
        text_t       t;
        logic [31:0] w;
        case (it.kind)
            KIND_DEC:
            begin
                w = it.value[31:0];
                if (w[31]) begin
                    w = -w;
                    t = digits_of({32'h0, w}, 10, 1'b0);
                    t.push_front("-");
                end else begin
                    t = digits_of({32'h0, w}, 10, 1'b0);
                end
            end
            KIND_HEXL: t = digits_of({32'h0, it.value[31:0]}, 16, 1'b0);
            KIND_HEXU: t = digits_of({32'h0, it.value[31:0]}, 16, 1'b1);
            KIND_PTR:
            begin
                if (it.value == 64'd0) begin
                    t = text_of("(nil)");
                end else begin
                    t = digits_of(it.value, 16, 1'b0);
                    t.push_front("x");
                    t.push_front("0");
                end
            end
            KIND_CHAR:
            begin
                if (it.value[7:0] == 8'd0) begin
                    t = text_of("(NILL)");
                end else begin
                    t.push_back(it.value[7:0]);
                end
            end
            default:
            begin
            end
        endcase
        return t;
    endfunction

    task automatic offer_item(in_t it, text_t chars, bit allow_gap);
        out_t c;
        if (allow_gap) begin
            while ($urandom_range(99) < 26) begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        for (int i = 0; i < chars.size(); i++) begin
            c.out_char = chars[i];
            c.last = (i == chars.size() - 1);
            expected_chars.push_back(c);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever begin
            #2 clk = ~clk;
        end
    end

    initial begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #2000000;
        $display("integer_to_ascii_formatter_tb: done, errors");
        $finish;
    end

    initial begin
        static row_t directed_rows[24] = '{
            '{KIND_DEC,       64'h0000_0000_0000_0000, "0"},
            '{KIND_DEC,       64'h0000_0000_7fff_ffff, "2147483647"},
            '{KIND_DEC,       64'h0000_0000_8000_0000, "-2147483648"},
            '{KIND_DEC,       64'hffff_ffff_ffff_ffff, "-1"},
            '{KIND_DEC,       64'hffff_ffff_0000_0005, "5"},
            '{KIND_DEC,       64'd1234567890,          ""},
            '{KIND_HEXL,      64'h0000_0000_0000_0000, "0"},
            '{KIND_HEXL,      64'h0000_0000_ffff_ffff, "ffffffff"},
            '{KIND_HEXL,      64'hffff_ffff_dead_beef, ""},
            '{KIND_HEXU,      64'hffff_ffff_0000_0000, "0"},
            '{KIND_HEXU,      64'h1234_5678_ffff_ffff, "FFFFFFFF"},
            '{KIND_HEXU,      64'h0000_0000_00ab_cdef, ""},
            '{KIND_PTR,       64'h0000_0000_0000_0000, "(nil)"},
            '{KIND_PTR,       64'hffff_ffff_ffff_ffff, "0xffffffffffffffff"},
            '{KIND_PTR,       64'h0000_0000_0000_0001, "0x1"},
            '{KIND_PTR,       64'h8000_0000_0000_0000, "0x8000000000000000"},
            '{KIND_PTR,       64'h0123_4567_89ab_cdef, ""},
            '{KIND_CHAR,      64'h0000_0000_0000_0000, "(NILL)"},
            '{KIND_CHAR,      64'hffff_ffff_ffff_ff00, "(NILL)"},
            '{KIND_CHAR,      64'h0000_0000_0000_0041, "A"},
            '{KIND_CHAR,      64'hffff_ffff_ffff_ffff, ""},
            '{KIND_UNUSED_LO, 64'h5555_aaaa_5555_aaaa, ""},
            '{3'(KIND_UNUSED_LO + 3'd1), 64'h0000_0000_0000_0000, ""},
            '{KIND_UNUSED_HI, 64'hffff_ffff_ffff_ffff, ""}
        };
        in_t it;
        int  counted;
        item_valid = 1'b0;
        item = '0;
        sender_done = 1'b0;
        bulk_started = 1'b0;
        counted = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (directed_rows[i]) begin
            it.kind = directed_rows[i].kind;
            it.value = directed_rows[i].value;
            if (directed_rows[i].text != "") begin
                offer_item(it, text_of(directed_rows[i].text), 1'b1);
            end else begin
                offer_item(it, format_text(it), 1'b1);
            end
        end
        bulk_started = 1'b1;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(19) == 0) begin
                it.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            end else begin
                it.kind = 3'($urandom_range(KIND_DEC, KIND_CHAR));
                counted++;
            end
            case ($urandom_range(5))
                0: it.value = {$urandom, $urandom};
                1: it.value = 64'($urandom_range(16));
                2: it.value = {$urandom, 32'hffff_ffff - 32'($urandom_range(16))};
                3: it.value = {$urandom, 32'h8000_0000 + 32'($urandom_range(16))};
                4: it.value = 64'h1 << $urandom_range(63);
                default: it.value = ~64'($urandom_range(16));
            endcase
            offer_item(it, format_text(it), (counted < 40) || (counted >= 70));
        end
        item_valid <= 1'b0;
        sender_done = 1'b1;
    end

    initial begin
        int   hold_left;
        bit   hold_done;
        out_t exp;
        result_ready = 1'b0;
        error_count = 0;
        chars_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("unexpected transfer: char %h last %b",
                                 result.out_char, result.last);
                    end
                end else begin
                    exp = expected_chars.pop_front();
                    if (result.out_char !== exp.out_char || result.last !== exp.last) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("mismatch: expected char %h last %b, got char %h last %b",
                                     exp.out_char, exp.last, result.out_char, result.last);
                        end
                    end
                end
            end
            if (bulk_started && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ready <= 1'b0;
            end else if (chars_seen >= 300 && chars_seen < 600) begin
                result_ready <= 1'b1;
            end else begin
                result_ready <= ($urandom_range(99) >= 26);
            end
        end
    end

    initial begin
        wait (sender_done);
        while (expected_chars.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("integer_to_ascii_formatter_tb: done, clean");
        end else begin
            $display("integer_to_ascii_formatter_tb: done, errors");
        end
        $finish;
    end

endmodule
